@@ rtl/hndl_pkg.sv @@
// ----------------------------------------------------------------------------
// hndl_pkg
// Shared types and constants of the mark-and-sweep handle table.
// ----------------------------------------------------------------------------
package hndl_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int HANDLE_W      = 10;
    localparam int COUNT_W       = 11;
    localparam int BYTES_W       = 48;
    localparam int LIMIT_W       = 32;
    localparam int SIZE_W        = 32;
    localparam int TYPE_W        = 32;
    localparam int KIND_W        = 3;

    localparam logic CFG_OBJ_LIMIT  = 1'b0;
    localparam logic CFG_BYTE_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        OP_ALLOC       = 3'd0,
        OP_LOOKUP      = 3'd1,
        OP_MARK        = 3'd2,
        OP_CLEAR_MARKS = 3'd3,
        OP_SWEEP       = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_OBJ_LIMIT  = 3'd1,
        ST_BYTE_LIMIT = 3'd2,
        ST_FULL       = 3'd3,
        ST_NOT_LIVE   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_LOOK,
        S_WALK_RD,
        S_WALK_WR
    } t_state;

    typedef struct packed {
        logic                alive;
        logic                mark;
        logic [KIND_W-1:0]   kind;
        logic [TYPE_W-1:0]   typ;
        logic [SIZE_W-1:0]   size;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        t_status             status;
        logic                live;
        logic [KIND_W-1:0]   kind;
        logic [TYPE_W-1:0]   typ;
        logic [SIZE_W-1:0]   size;
        logic [COUNT_W-1:0]  freed;
    } t_result;

endpackage

@@ rtl/hndl_ram.sv @@
// ----------------------------------------------------------------------------
// hndl_ram
// Dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hndl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/handle_allocator_mark_sweep.sv @@
// ----------------------------------------------------------------------------
// handle_allocator_mark_sweep
// Object handle table with LIFO free stack and mark-and-sweep reclamation.
// ----------------------------------------------------------------------------
// Headers live in one entry RAM, freed handles in a stack RAM. Allocate ends
// in the execute state when it appends or is refused; a freed handle is read
// from the stack there and written in the pop state, and the very first
// allocate creates the null entry before it retries as an append. Lookup and
// mark read the entry RAM and finish in the look state, or in the execute
// state when the handle lies beyond the used entries. Reset marks and sweep
// walk entries 0 to used-1 with a read and a write-back state each. A new beat
// is taken once the previous result has left the internal result register;
// the output register holds a result while the next item runs. No clearing
// pass is needed after reset: the used-entry count bounds every table read.
module handle_allocator_mark_sweep
    import hndl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [BYTES_W-1:0]  i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_operation,
    input  logic [KIND_W-1:0]   i_object_kind,
    input  logic [TYPE_W-1:0]   i_object_type,
    input  logic [SIZE_W-1:0]   i_object_bytes,
    input  logic [HANDLE_W-1:0] i_target_handle,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [HANDLE_W-1:0] o_result_handle,
    output logic [2:0]          o_status,
    output logic                o_entry_live,
    output logic [KIND_W-1:0]   o_entry_kind,
    output logic [TYPE_W-1:0]   o_entry_type,
    output logic [SIZE_W-1:0]   o_entry_bytes,
    output logic [COUNT_W-1:0]  o_freed_count,
    output logic [COUNT_W-1:0]  o_live_count,
    output logic [BYTES_W-1:0]  o_live_total_bytes
);

    localparam logic [COUNT_W-1:0] ENTRIES = COUNT_W'(TABLE_ENTRIES);

    t_state r_state, n_state;

    logic [LIMIT_W-1:0]  r_obj_limit;
    logic [BYTES_W-1:0]  r_byte_limit;
    logic [COUNT_W-1:0]  r_table_used;
    logic [COUNT_W-1:0]  r_top;
    logic [COUNT_W-1:0]  r_live_objects;
    logic [BYTES_W-1:0]  r_live_bytes;
    logic [COUNT_W-1:0]  r_idx;
    logic [COUNT_W-1:0]  r_freed;

    logic [2:0]          r_op;
    logic [KIND_W-1:0]   r_kind;
    logic [TYPE_W-1:0]   r_type;
    logic [SIZE_W-1:0]   r_bytes;
    logic [HANDLE_W-1:0] r_handle;

    t_result             r_res;
    logic                r_res_valid;
    t_result             r_out;
    logic                r_out_valid;
    logic [COUNT_W-1:0]  r_out_live;
    logic [BYTES_W-1:0]  r_out_bytes;

    logic                ent_we, ent_re;
    logic [HANDLE_W-1:0] ent_waddr, ent_raddr;
    t_entry              ent_wdata, ent_rdata;
    logic                stk_we, stk_re;
    logic [HANDLE_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    logic                fin;
    t_result             res;
    logic                alloc_ok, null_init, pop, append, walk_step, walk_free;

    logic                accept;
    logic                obj_fail, byte_fail, full_fail, in_range;
    logic [BYTES_W-1:0]  byte_room;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE) && !r_res_valid;
    assign in_range = {1'b0, r_handle} < r_table_used;

    assign byte_room = r_byte_limit - r_live_bytes;
    assign obj_fail  = (r_obj_limit != '0) &&
                       ({{(LIMIT_W-COUNT_W){1'b0}}, r_live_objects} >= r_obj_limit);
    assign byte_fail = (r_byte_limit != '0) &&
                       ((r_live_bytes > r_byte_limit) ||
                        ({{(BYTES_W-SIZE_W){1'b0}}, r_bytes} > byte_room));
    assign full_fail = (r_top == '0) && (r_table_used >= ENTRIES);

    hndl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    hndl_ram #(.WIDTH(HANDLE_W), .DEPTH(TABLE_ENTRIES)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_ALLOC: begin
                        if (obj_fail || byte_fail || full_fail) begin
                            n_state = S_IDLE;
                        end else if (r_table_used == '0) begin
                            n_state = S_EXEC;
                        end else if (r_top != '0) begin
                            n_state = S_POP;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    OP_LOOKUP, OP_MARK: begin
                        n_state = in_range ? S_LOOK : S_IDLE;
                    end
                    OP_CLEAR_MARKS, OP_SWEEP: begin
                        n_state = S_WALK_RD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_POP:     n_state = S_IDLE;
            S_LOOK:    n_state = S_IDLE;
            S_WALK_RD: n_state = (r_idx >= r_table_used) ? S_IDLE : S_WALK_WR;
            S_WALK_WR: n_state = S_WALK_RD;
            default:   n_state = S_IDLE;
        endcase
    end

    // Memory controls and result
    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = '0;
        ent_wdata = '0;
        ent_re    = 1'b0;
        ent_raddr = r_idx[HANDLE_W-1:0];
        stk_we    = 1'b0;
        stk_waddr = r_top[HANDLE_W-1:0];
        stk_wdata = r_idx[HANDLE_W-1:0];
        stk_re    = 1'b0;
        stk_raddr = HANDLE_W'(r_top - 1'b1);
        fin       = 1'b0;
        res       = '0;
        res.status = ST_OK;
        alloc_ok  = 1'b0;
        null_init = 1'b0;
        pop       = 1'b0;
        append    = 1'b0;
        walk_step = 1'b0;
        walk_free = 1'b0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_ALLOC: begin
                        priority if (obj_fail) begin
                            fin = 1'b1;
                            res.status = ST_OBJ_LIMIT;
                        end else if (byte_fail) begin
                            fin = 1'b1;
                            res.status = ST_BYTE_LIMIT;
                        end else if (full_fail) begin
                            fin = 1'b1;
                            res.status = ST_FULL;
                        end else if (r_table_used == '0) begin
                            // create the null entry, then retry as an append
                            ent_we    = 1'b1;
                            ent_waddr = '0;
                            null_init = 1'b1;
                        end else if (r_top != '0) begin
                            stk_re = 1'b1;
                            pop    = 1'b1;
                        end else begin
                            ent_we     = 1'b1;
                            ent_waddr  = r_table_used[HANDLE_W-1:0];
                            ent_wdata  = '{alive: 1'b1, mark: 1'b0, kind: r_kind,
                                           typ: r_type, size: r_bytes};
                            append     = 1'b1;
                            alloc_ok   = 1'b1;
                            fin        = 1'b1;
                            res.handle = r_table_used[HANDLE_W-1:0];
                        end
                    end
                    OP_LOOKUP, OP_MARK: begin
                        if (in_range) begin
                            ent_re    = 1'b1;
                            ent_raddr = r_handle;
                        end else begin
                            fin = 1'b1;
                            res.status = ST_NOT_LIVE;
                        end
                    end
                    OP_CLEAR_MARKS, OP_SWEEP: begin
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_POP: begin
                ent_we     = 1'b1;
                ent_waddr  = stk_rdata;
                ent_wdata  = '{alive: 1'b1, mark: 1'b0, kind: r_kind,
                               typ: r_type, size: r_bytes};
                alloc_ok   = 1'b1;
                fin        = 1'b1;
                res.handle = stk_rdata;
            end
            S_LOOK: begin
                fin = 1'b1;
                if (!ent_rdata.alive) begin
                    res.status = ST_NOT_LIVE;
                end else if (r_op == OP_LOOKUP) begin
                    res.live = 1'b1;
                    res.kind = ent_rdata.kind;
                    res.typ  = ent_rdata.typ;
                    res.size = ent_rdata.size;
                end else begin
                    ent_we         = 1'b1;
                    ent_waddr      = r_handle;
                    ent_wdata      = ent_rdata;
                    ent_wdata.mark = 1'b1;
                end
            end
            S_WALK_RD: begin
                if (r_idx >= r_table_used) begin
                    fin = 1'b1;
                    res.freed = (r_op == OP_SWEEP) ? r_freed : '0;
                end else begin
                    ent_re = 1'b1;
                end
            end
            S_WALK_WR: begin
                walk_step = 1'b1;
                ent_we    = 1'b1;
                ent_waddr = r_idx[HANDLE_W-1:0];
                ent_wdata = ent_rdata;
                ent_wdata.mark = 1'b0;
                if (r_op == OP_SWEEP && ent_rdata.alive && !ent_rdata.mark) begin
                    walk_free       = 1'b1;
                    ent_wdata.alive = 1'b0;
                    ent_wdata.typ   = '0;
                    ent_wdata.size  = '0;
                    stk_we          = r_top < ENTRIES;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_obj_limit    <= '0;
            r_byte_limit   <= '0;
            r_table_used   <= '0;
            r_top          <= '0;
            r_live_objects <= '0;
            r_live_bytes   <= '0;
            r_idx          <= '0;
            r_freed        <= '0;
            r_res_valid    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_OBJ_LIMIT) begin
                    r_obj_limit <= i_cfg_data[LIMIT_W-1:0];
                end else begin
                    r_byte_limit <= i_cfg_data;
                end
            end

            if (accept) begin
                r_idx   <= '0;
                r_freed <= '0;
            end
            if (null_init) begin
                r_table_used <= COUNT_W'(1);
            end
            if (append) begin
                r_table_used <= r_table_used + 1'b1;
            end
            if (pop) begin
                r_top <= r_top - 1'b1;
            end
            if (alloc_ok) begin
                r_live_objects <= r_live_objects + 1'b1;
                r_live_bytes   <= r_live_bytes + {{(BYTES_W-SIZE_W){1'b0}}, r_bytes};
            end
            if (walk_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (walk_free) begin
                // saturate the live object and byte counters at zero
                if (r_live_objects != '0) begin
                    r_live_objects <= r_live_objects - 1'b1;
                end
                if (r_live_bytes >= {{(BYTES_W-SIZE_W){1'b0}}, ent_rdata.size}) begin
                    r_live_bytes <= r_live_bytes -
                                    {{(BYTES_W-SIZE_W){1'b0}}, ent_rdata.size};
                end else begin
                    r_live_bytes <= '0;
                end
                if (r_top < ENTRIES) begin
                    r_top <= r_top + 1'b1;
                end
                r_freed <= r_freed + 1'b1;
            end

            // advance the result into the output register when it is free
            if (fin) begin
                r_res_valid <= 1'b1;
            end else if (r_res_valid && (!r_out_valid || i_ready)) begin
                r_res_valid <= 1'b0;
            end
            if (r_res_valid && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_operation;
            r_kind   <= i_object_kind;
            r_type   <= i_object_type;
            r_bytes  <= i_object_bytes;
            r_handle <= i_target_handle;
        end
        if (fin) begin
            r_res <= res;
        end
        if (r_res_valid && (!r_out_valid || i_ready)) begin
            r_out       <= r_res;
            r_out_live  <= r_live_objects;
            r_out_bytes <= r_live_bytes;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_result_handle    = r_out.handle;
    assign o_status           = r_out.status;
    assign o_entry_live       = r_out.live;
    assign o_entry_kind       = r_out.kind;
    assign o_entry_type       = r_out.typ;
    assign o_entry_bytes      = r_out.size;
    assign o_freed_count      = r_out.freed;
    assign o_live_count       = r_out_live;
    assign o_live_total_bytes = r_out_bytes;

    a_live_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live_objects <= r_table_used)
        else $error("live count exceeds used entries");

    a_handles_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_POP && r_table_used != '0) |->
        ({1'b0, r_top} + {1'b0, r_live_objects} + 12'd1 == {1'b0, r_table_used}))
        else $error("free plus live handles do not match used entries");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> r_state == S_IDLE)
        else $error("result pending while an item is in progress");

endmodule
